// ----- rtl/omni_wheel_speed_with_normalize_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef OMNI_WHEEL_SPEED_WITH_NORMALIZE_MACROS_SVH
`define OMNI_WHEEL_SPEED_WITH_NORMALIZE_MACROS_SVH

`ifndef SYNTHESIS
`define OWSN_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define OWSN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define OWSN_ASSERT(lbl, cond)
`define OWSN_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ----- rtl/owsn_pkg.sv -----
// ----------------------------------------------------------------------------
// owsn_pkg
// Shared types, constants and saturation helper for the omni wheel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owsn_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int DIV_STEPS   = 31;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATE_RADIUS   = 2'd0,
        CFG_SPEED_CAP       = 2'd1,
        CFG_DIRECTION_INV   = 2'd2
    } cfg_idx_t;

    typedef logic signed [31:0] speed_t;
    typedef speed_t [WHEEL_COUNT-1:0] wheel_vec_t;

    typedef struct packed {
        logic [WHEEL_COUNT-1:0][61:0] prod;
        logic [31:0]                  divisor;
        logic [WHEEL_COUNT-1:0]       neg;
        wheel_vec_t                   spd;
        logic                         scaled;
    } div_item_t;

    localparam speed_t SPEED_MAX = 32'sh7FFF_FFFF;
    localparam speed_t SPEED_MIN = 32'sh8000_0000;

    function automatic speed_t sat33(input logic signed [32:0] v);
        speed_t r;
        if (v[32] != v[31])
            r = v[32] ? SPEED_MIN : SPEED_MAX;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- rtl/omni_wheel_speed_with_normalize.sv -----
// ----------------------------------------------------------------------------
// omni_wheel_speed_with_normalize
// Four-wheel omni inverse kinematics with speed limit normalization.
//
// A request on the s channel carries vel_x, vel_y and yaw_rate (signed
// Q16.16). One result on the m channel carries the rear, right, front and
// left wheel speeds in tdata and the was_scaled flag in tuser.
// Configuration registers (rotate radius, speed cap, direction invert)
// load through cfg_we / cfg_index / cfg_data; write them while idle.
// The pipeline has three kinematics stages, two peak and product
// stages, a 31-stage restoring divider (one quotient bit per stage per
// wheel) and an output register. Throughput is one request per cycle while m_tready is high.
// Each stage holds its own valid bit, so bubbles close up and s_tready
// stays high while any stage has room. When m_tready is low the result
// holds and the pipeline fills behind it; nothing is lost or repeated.
// Reset clears all valid bits and loads the default register values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "omni_wheel_speed_with_normalize_macros.svh"

module omni_wheel_speed_with_normalize (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [95:0]                        s_tdata,  // vel_x, vel_y, yaw_rate
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [127:0]                       m_tdata,  // rear, right, front, left
    output logic                               m_tuser,  // was_scaled
    input  logic                               cfg_we,
    input  logic [owsn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [30:0]                        cfg_data
);
    import owsn_pkg::*;

    logic [30:0] radius_reg;
    logic [30:0] limit_reg;
    logic [3:0]  dir_reg;

    logic       kin_valid, kin_ready, peak_valid, peak_ready;
    wheel_vec_t kin_spd, out_spd;
    div_item_t  peak_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd19661;
            limit_reg  <= 31'd196608;
            dir_reg    <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROTATE_RADIUS:   radius_reg <= cfg_data;
                CFG_SPEED_CAP:       limit_reg  <= cfg_data;
                CFG_DIRECTION_INV:   dir_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    owsn_kin u_kin (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .vel_x            (s_tdata[31:0]),
        .vel_y            (s_tdata[63:32]),
        .yaw_rate         (s_tdata[95:64]),
        .rotate_radius    (radius_reg),
        .direction_invert (dir_reg),
        .out_valid        (kin_valid),
        .out_ready        (kin_ready),
        .out_spd          (kin_spd)
    );

    owsn_peak u_peak (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (kin_valid),
        .in_ready        (kin_ready),
        .in_spd          (kin_spd),
        .speed_cap       (limit_reg),
        .out_valid       (peak_valid),
        .out_ready       (peak_ready),
        .out_item        (peak_item)
    );

    owsn_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (peak_valid),
        .in_ready   (peak_ready),
        .in_item    (peak_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_spd    (out_spd),
        .out_scaled (m_tuser)
    );

    assign m_tdata = {out_spd[3], out_spd[2], out_spd[1], out_spd[0]};

    `OWSN_ASSERT_IMPL(a_empty_tail_accepts, !m_tvalid, s_tready)
    `OWSN_ASSERT_IMPL(a_rear_within_limit, m_tvalid && m_tuser,
        $signed(out_spd[0]) <= $signed({1'b0, limit_reg}) &&
        $signed(out_spd[0]) >= -$signed({1'b0, limit_reg}))
    `OWSN_ASSERT_IMPL(a_front_within_limit, m_tvalid && m_tuser,
        $signed(out_spd[2]) <= $signed({1'b0, limit_reg}) &&
        $signed(out_spd[2]) >= -$signed({1'b0, limit_reg}))

endmodule

// ----- rtl/owsn_kin.sv -----
// ----------------------------------------------------------------------------
// owsn_kin
// Tangential speed, wheel sums and direction inversion in three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owsn_kin (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  owsn_pkg::speed_t    vel_x,
    input  owsn_pkg::speed_t    vel_y,
    input  owsn_pkg::speed_t    yaw_rate,
    input  logic [30:0]         rotate_radius,
    input  logic [3:0]          direction_invert,
    output logic                out_valid,
    input  logic                out_ready,
    output owsn_pkg::wheel_vec_t out_spd
);
    import owsn_pkg::*;

    logic [2:0] v_reg;
    logic [2:0] en;

    logic signed [63:0] prod_reg, prod_next;
    speed_t vx1_reg, vy1_reg, vx2_reg, vy2_reg;
    speed_t t_reg, t_next;
    wheel_vec_t spd_reg, spd_next;
    logic signed [47:0] q;
    speed_t raw [WHEEL_COUNT];

    assign en[2]     = !v_reg[2] || out_ready;
    assign en[1]     = !v_reg[1] || en[2];
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[2];
    assign out_spd   = spd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    assign prod_next = yaw_rate * $signed({1'b0, rotate_radius});

    always_comb
    begin
        q = prod_reg[63:16];
        if (q[47:31] != {17{q[31]}})
            t_next = q[47] ? SPEED_MIN : SPEED_MAX;
        else
            t_next = q[31:0];
    end

    always_comb
    begin
        raw[0] = sat33({vy2_reg[31], vy2_reg} + {t_reg[31], t_reg});
        raw[1] = sat33({t_reg[31], t_reg} - {vx2_reg[31], vx2_reg});
        raw[2] = sat33({t_reg[31], t_reg} - {vy2_reg[31], vy2_reg});
        raw[3] = sat33({vx2_reg[31], vx2_reg} + {t_reg[31], t_reg});
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            if (direction_invert[i])
                spd_next[i] = sat33(33'sd0 - {raw[i][31], raw[i]});
            else
                spd_next[i] = raw[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
            vx1_reg  <= vel_x;
            vy1_reg  <= vel_y;
        end
        if (en[1])
        begin
            t_reg   <= t_next;
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
        end
        if (en[2])
            spd_reg <= spd_next;
    end

endmodule

// ----- rtl/owsn_peak.sv -----
// ----------------------------------------------------------------------------
// owsn_peak
// Largest magnitude, limit compare and scaling products in two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owsn_peak (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  owsn_pkg::wheel_vec_t in_spd,
    input  logic [30:0]          speed_cap,
    output logic                 out_valid,
    input  logic                 out_ready,
    output owsn_pkg::div_item_t  out_item
);
    import owsn_pkg::*;

    logic [1:0] v_reg;
    logic [1:0] en;

    logic [WHEEL_COUNT-1:0][31:0] abs_reg, abs_next;
    logic [31:0] big_reg, big_next, m01, m23;
    wheel_vec_t spd_reg;
    div_item_t item_reg, item_next;

    assign en[1]     = !v_reg[1] || out_ready;
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[1];
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < WHEEL_COUNT; i++)
            abs_next[i] = in_spd[i][31] ? 32'(-in_spd[i]) : 32'(in_spd[i]);
        m01      = (abs_next[0] > abs_next[1]) ? abs_next[0] : abs_next[1];
        m23      = (abs_next[2] > abs_next[3]) ? abs_next[2] : abs_next[3];
        big_next = (m01 > m23) ? m01 : m23;
    end

    always_comb
    begin
        item_next.divisor = big_reg;
        item_next.spd     = spd_reg;
        item_next.scaled  = big_reg > {1'b0, speed_cap};
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            item_next.prod[i] = 62'(abs_reg[i]) * 62'(speed_cap);
            item_next.neg[i]  = spd_reg[i][31];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            abs_reg <= abs_next;
            big_reg <= big_next;
            spd_reg <= in_spd;
        end
        if (en[1])
            item_reg <= item_next;
    end

endmodule

// ----- rtl/owsn_div.sv -----
// ----------------------------------------------------------------------------
// owsn_div
// Pipelined restoring divider, one quotient bit per stage, four lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owsn_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  owsn_pkg::div_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output owsn_pkg::wheel_vec_t out_spd,
    output logic                 out_scaled
);
    import owsn_pkg::*;

    localparam int LAST = DIV_STEPS;

    logic [LAST:0] v_reg;
    logic [LAST:0] en;

    div_item_t item_reg [DIV_STEPS];
    logic [WHEEL_COUNT-1:0][31:0]          rem_reg [DIV_STEPS];
    logic [WHEEL_COUNT-1:0][DIV_STEPS-1:0] quo_reg [DIV_STEPS];

    wheel_vec_t spd_reg, spd_next;
    logic       scaled_reg;

    assign en[LAST]   = !v_reg[LAST] || out_ready;
    assign in_ready   = en[0];
    assign out_valid  = v_reg[LAST];
    assign out_spd    = spd_reg;
    assign out_scaled = scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int j = 1; j <= LAST; j++)
            begin
                if (en[j])
                    v_reg[j] <= v_reg[j-1];
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            div_item_t                             item_in;
            logic [WHEEL_COUNT-1:0][31:0]          rem_in, rem_next;
            logic [WHEEL_COUNT-1:0][DIV_STEPS-1:0] quo_in, quo_next;
            logic [32:0]                           trial [WHEEL_COUNT];

            assign en[k] = !v_reg[k] || en[k+1];

            if (k == 0)
            begin : g_first
                assign item_in = in_item;
                always_comb
                begin
                    for (int w = 0; w < WHEEL_COUNT; w++)
                    begin
                        rem_in[w] = {1'b0, in_item.prod[w][61:31]};
                        quo_in[w] = '0;
                    end
                end
            end
            else
            begin : g_next
                assign item_in = item_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign quo_in  = quo_reg[k-1];
            end

            always_comb
            begin
                for (int w = 0; w < WHEEL_COUNT; w++)
                begin
                    trial[w] = {rem_in[w], item_in.prod[w][DIV_STEPS-1-k]};
                    if (trial[w] >= {1'b0, item_in.divisor})
                    begin
                        rem_next[w] = 32'(trial[w] - {1'b0, item_in.divisor});
                        quo_next[w] = {quo_in[w][DIV_STEPS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[w] = trial[w][31:0];
                        quo_next[w] = {quo_in[w][DIV_STEPS-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    item_reg[k] <= item_in;
                    rem_reg[k]  <= rem_next;
                    quo_reg[k]  <= quo_next;
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            if (!item_reg[LAST-1].scaled)
                spd_next[w] = item_reg[LAST-1].spd[w];
            else if (item_reg[LAST-1].neg[w])
                spd_next[w] = 32'sd0 - $signed({1'b0, quo_reg[LAST-1][w]});
            else
                spd_next[w] = $signed({1'b0, quo_reg[LAST-1][w]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            spd_reg    <= spd_next;
            scaled_reg <= item_reg[LAST-1].scaled;
        end
    end

endmodule
